// ===== hdl/fvn_pkg.sv =====
package fvn_pkg;

  // register indexes on the configuration port
  localparam logic REG_OFFSET  = 1'b0;
  localparam logic REG_OCTAVES = 1'b1;

  localparam logic [15:0] OFFSET_RST  = 16'd0;
  localparam logic [3:0]  OCTAVES_RST = 4'd5;

  // register stages inside one octave lane
  localparam int OCT_STAGES = 14;

  // ceil(2^30 / 25), exact floor quotient for dividends below 2^30
  localparam logic [25:0] RECIP_25 = 26'd42949673;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

  localparam logic [31:0] HASH_Y_MUL = 32'd57;
  localparam logic [31:0] HASH_MUL   = 32'd15731;
  localparam logic [31:0] HASH_ADD1  = 32'd789221;
  localparam logic [31:0] HASH_ADD2  = 32'd1376312589;

  localparam logic [15:0] AMP_Q16 [8] = '{
    16'd52429, 16'd36700, 16'd25690, 16'd17983,
    16'd12588, 16'd8812, 16'd6168, 16'd4318
  };

  // (1 - cos(theta)) / 2 in Q.16, theta in Q.30, taylor series to ten terms
  function automatic logic [16:0] cos_weight(input logic [63:0] theta);
    logic [63:0] t2;
    logic [63:0] term;
    logic signed [63:0] c;
    logic signed [63:0] r;
    t2   = (theta * theta) >> 30;
    term = 64'd1 << 30;
    c    = ONE_Q30;
    term = ((term * t2) >> 30) / 2;   c = c - $signed(term);
    term = ((term * t2) >> 30) / 12;  c = c + $signed(term);
    term = ((term * t2) >> 30) / 30;  c = c - $signed(term);
    term = ((term * t2) >> 30) / 56;  c = c + $signed(term);
    term = ((term * t2) >> 30) / 90;  c = c - $signed(term);
    term = ((term * t2) >> 30) / 132; c = c + $signed(term);
    term = ((term * t2) >> 30) / 182; c = c - $signed(term);
    term = ((term * t2) >> 30) / 240; c = c + $signed(term);
    term = ((term * t2) >> 30) / 306; c = c - $signed(term);
    term = ((term * t2) >> 30) / 380; c = c + $signed(term);
    if (c > ONE_Q30) begin
      c = ONE_Q30;
    end
    r = (ONE_Q30 - c + 64'sd16384) >>> 15;
    return r[16:0];
  endfunction

endpackage

// ===== hdl/fvn_pix_if.sv =====
interface fvn_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] row;
  logic [9:0] column;

  modport source (output valid, output row, output column, input ready);
  modport sink (input valid, input row, input column, output ready);
endinterface

// ===== hdl/fvn_lvl_if.sv =====
interface fvn_lvl_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       clipped;

  modport source (output valid, output level, output clipped, input ready);
  modport sink (input valid, input level, input clipped, output ready);
endinterface

// ===== hdl/fvn_octave.sv =====
module fvn_octave #(
  parameter int K               = 0,
  parameter int MAX_OCTAVES     = 8,
  parameter int COS_TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic [fvn_pkg::OCT_STAGES-1:0]  adv_i,
  input  logic [16:0]                     x_i,
  input  logic [16:0]                     y_i,
  input  logic [3:0]                      cnt_i,
  output logic signed [35:0]              prod_o
);

  localparam int ZW = 17 + MAX_OCTAVES - 1;
  localparam int AW = ZW - 4;
  localparam int QW = ZW + 10;
  localparam int XW = ZW - 6;
  localparam int IW = $clog2(COS_TABLE_DEPTH);
  localparam int FW = 16 + $clog2(COS_TABLE_DEPTH + 1);
  localparam logic [15:0] AMP = fvn_pkg::AMP_Q16[K];

  // cosine weight rom, mirrored around the midpoint
  logic [16:0] wrom [COS_TABLE_DEPTH];
  for (genvar gi = 0; gi < COS_TABLE_DEPTH; gi++) begin : g_rom
    localparam bit MIR = (2 * gi > COS_TABLE_DEPTH);
    localparam int J = MIR ? COS_TABLE_DEPTH - gi : gi;
    localparam logic [63:0] TH = (fvn_pkg::PI_Q30 * 64'(J)) / COS_TABLE_DEPTH;
    localparam logic [16:0] WD = fvn_pkg::cos_weight(TH);
    assign wrom[gi] = MIR ? 17'd65536 - WD : WD;
  end

  // floor(16384 * b / 25) for the remainder b of the division by 25
  logic [13:0] qtab [32];
  for (genvar gi = 0; gi < 32; gi++) begin : g_qtab
    localparam logic [13:0] QV = (gi < 25) ? 14'((16384 * gi) / 25) : 14'd0;
    assign qtab[gi] = QV;
  end

  // stage 1..3: scaled coordinate = floor(coord * 2^k * 65536 / 100)
  logic [ZW-1:0]    z_d [2];
  logic [ZW-1:0]    z_q [2];
  logic [ZW+25:0]   m_q [2];
  logic [AW-1:0]    a_q [2];
  logic [4:0]       b_q [2];
  logic [XW-1:0]    xi_q [2];
  logic [15:0]      fr_q [2];

  logic [AW-1:0]    a_d [2];
  logic [ZW-1:0]    r_d [2];
  logic [QW-1:0]    qs_d [2];

  // stage 4..8: lattice hash of the 4x4 neighborhood
  logic [31:0]        n_d   [16];
  logic [31:0]        n4_q  [16];
  logic [31:0]        n5_q  [16];
  logic [31:0]        n6_q  [16];
  logic [31:0]        sq_q  [16];
  logic [31:0]        t_q   [16];
  logic [31:0]        u_q   [16];
  logic signed [17:0] lat_q [16];
  logic [31:0]        h_d   [16];

  logic [16:0] wx_q [4:9];
  logic [16:0] wy_q [4:11];
  logic [FW-1:0] ix_d;
  logic [FW-1:0] iy_d;

  // stage 9..14: smoothing, blending, amplitude
  logic signed [17:0] sm_d [4];
  logic signed [17:0] sm_q [4];
  logic signed [17:0] v1_q;
  logic signed [17:0] v3_q;
  logic signed [36:0] p1_q;
  logic signed [36:0] p2_q;
  logic signed [18:0] i1_q;
  logic signed [18:0] i2_q;
  logic signed [18:0] i1b_q;
  logic signed [37:0] p3_q;
  logic signed [18:0] oct_q;
  logic signed [35:0] prod_q;

  logic signed [18:0] d1_d;
  logic signed [18:0] d2_d;
  logic signed [19:0] d3_d;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      z_d[c]  = ZW'(c == 0 ? x_i : y_i) << K;
      a_d[c]  = m_q[c][ZW+25:30];
      r_d[c]  = z_q[c] - ZW'(ZW'(a_d[c]) * ZW'(25));
      qs_d[c] = {a_q[c], 14'd0} + QW'(qtab[b_q[c]]);
    end
    for (int gy = 0; gy < 4; gy++) begin
      for (int gx = 0; gx < 4; gx++) begin
        h_d[gy*4+gx] = (32'(xi_q[0]) + 32'(gx) - 32'd1)
                     + (32'(xi_q[1]) + 32'(gy) - 32'd1) * fvn_pkg::HASH_Y_MUL;
        n_d[gy*4+gx] = (h_d[gy*4+gx] << 13) ^ h_d[gy*4+gx];
      end
    end
    ix_d = FW'(fr_q[0]) * FW'(COS_TABLE_DEPTH);
    iy_d = FW'(fr_q[1]) * FW'(COS_TABLE_DEPTH);
  end

  always_comb begin
    logic signed [23:0] s;
    int ax;
    int by;
    for (int p = 0; p < 4; p++) begin
      ax = p & 1;
      by = p >> 1;
      s = 24'(lat_q[by*4+ax]) + 24'(lat_q[by*4+ax+2])
        + 24'(lat_q[(by+2)*4+ax]) + 24'(lat_q[(by+2)*4+ax+2])
        + 24'(2) * (24'(lat_q[(by+1)*4+ax]) + 24'(lat_q[(by+1)*4+ax+2])
                  + 24'(lat_q[by*4+ax+1]) + 24'(lat_q[(by+2)*4+ax+1]))
        + 24'(4) * 24'(lat_q[(by+1)*4+ax+1]);
      sm_d[p] = 18'(s >>> 4);
    end
  end

  assign d1_d = sm_q[1] - sm_q[0];
  assign d2_d = sm_q[3] - sm_q[2];
  assign d3_d = i2_q - i1_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 2; c++) begin
      if (adv_i[0]) begin
        z_q[c] <= z_d[c];
        m_q[c] <= (ZW+26)'(z_d[c]) * (ZW+26)'(fvn_pkg::RECIP_25);
      end
      if (adv_i[1]) begin
        a_q[c] <= a_d[c];
        b_q[c] <= r_d[c][4:0];
      end
      if (adv_i[2]) begin
        xi_q[c] <= qs_d[c][QW-1:16];
        fr_q[c] <= qs_d[c][15:0];
      end
    end
    if (adv_i[3]) begin
      wx_q[4] <= wrom[ix_d[16 +: IW]];
      wy_q[4] <= wrom[iy_d[16 +: IW]];
    end
    for (int s = 5; s <= 9; s++) begin
      if (adv_i[s-1]) begin
        wx_q[s] <= wx_q[s-1];
      end
    end
    for (int s = 5; s <= 11; s++) begin
      if (adv_i[s-1]) begin
        wy_q[s] <= wy_q[s-1];
      end
    end
    for (int g = 0; g < 16; g++) begin
      if (adv_i[3]) begin
        n4_q[g] <= n_d[g];
      end
      if (adv_i[4]) begin
        n5_q[g] <= n4_q[g];
        sq_q[g] <= n4_q[g] * n4_q[g];
      end
      if (adv_i[5]) begin
        n6_q[g] <= n5_q[g];
        t_q[g]  <= sq_q[g] * fvn_pkg::HASH_MUL + fvn_pkg::HASH_ADD1;
      end
      if (adv_i[6]) begin
        u_q[g] <= n6_q[g] * t_q[g];
      end
      if (adv_i[7]) begin
        lat_q[g] <= 18'sd65536
                  - $signed({1'b0, 17'((u_q[g] + fvn_pkg::HASH_ADD2) >> 14)});
      end
    end
    if (adv_i[8]) begin
      sm_q <= sm_d;
    end
    if (adv_i[9]) begin
      v1_q <= sm_q[0];
      v3_q <= sm_q[2];
      p1_q <= d1_d * $signed({1'b0, wx_q[9]});
      p2_q <= d2_d * $signed({1'b0, wx_q[9]});
    end
    if (adv_i[10]) begin
      i1_q <= v1_q + 19'(p1_q >>> 16);
      i2_q <= v3_q + 19'(p2_q >>> 16);
    end
    if (adv_i[11]) begin
      i1b_q <= i1_q;
      p3_q  <= d3_d * $signed({1'b0, wy_q[11]});
    end
    if (adv_i[12]) begin
      oct_q <= i1b_q + 19'(p3_q >>> 16);
    end
    if (adv_i[13]) begin
      // octaves past the configured count contribute nothing
      prod_q <= (4'(K) < cnt_i) ? 36'(oct_q * $signed({1'b0, AMP})) : 36'sd0;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/fractal_value_noise_pixel_core.sv =====
// path: an accepted pixel passes the offset register, the octave lanes, the adder tree and the level register
// throughput: one pixel per cycle while the output is not stalled, set by a lane of register stages per octave
// stalls: a full stage holds when the one after it is full and blocked
// reset: asynchronous, clears all valid bits, offset 0, num_octaves 5
module fractal_value_noise_pixel_core #(
  parameter int MAX_OCTAVES     = 8,
  parameter int COS_TABLE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fvn_pix_if.sink     pix_i,
  fvn_lvl_if.source   lvl_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NS = fvn_pkg::OCT_STAGES + 5;
  localparam int SO = fvn_pkg::OCT_STAGES + 1;

  logic [15:0] offset_q;
  logic [3:0]  octaves_q;
  logic [3:0]  cnt;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  logic [16:0] x_q;
  logic [16:0] y_q;

  logic signed [35:0] prod [8];
  logic signed [36:0] s2_q [4];
  logic signed [37:0] s4_q [2];
  logic signed [38:0] tot_q;
  logic [37:0] mag;
  logic [46:0] scl;
  logic        clip;
  logic [7:0]  level_q;
  logic        clipped_q;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= fvn_pkg::OFFSET_RST;
      octaves_q <= fvn_pkg::OCTAVES_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        fvn_pkg::REG_OFFSET:  offset_q  <= pwdata[15:0];
        fvn_pkg::REG_OCTAVES: octaves_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      fvn_pkg::REG_OFFSET:  prdata = {16'd0, offset_q};
      fvn_pkg::REG_OCTAVES: prdata = {28'd0, octaves_q};
      default:              prdata = 32'd0;
    endcase
  end

  assign cnt = (octaves_q > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octaves_q;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    en[NS-1] = !v_q[NS-1] || lvl_o.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= pix_i.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q <= 17'(pix_i.row) + 17'(offset_q);
      y_q <= 17'(pix_i.column) + 17'(offset_q);
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_oct
    if (k < MAX_OCTAVES) begin : g_on
      fvn_octave #(
        .K               (k),
        .MAX_OCTAVES     (MAX_OCTAVES),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
      ) u_octave (
        .clk_i  (clk_i),
        .adv_i  (en[fvn_pkg::OCT_STAGES:1]),
        .x_i    (x_q),
        .y_i    (y_q),
        .cnt_i  (cnt),
        .prod_o (prod[k])
      );
    end else begin : g_off
      assign prod[k] = 36'sd0;
    end
  end

  // q.32 sum over octaves, then |sum| * 255 >> 32
  assign mag  = tot_q[38] ? 38'(-tot_q) : 38'(tot_q);
  assign scl  = (47'(mag) << 8) - 47'(mag);
  assign clip = |scl[46:40];

  always_ff @(posedge clk_i) begin
    if (en[SO]) begin
      for (int i = 0; i < 4; i++) begin
        s2_q[i] <= 37'(prod[2*i]) + 37'(prod[2*i+1]);
      end
    end
    if (en[SO+1]) begin
      for (int i = 0; i < 2; i++) begin
        s4_q[i] <= 38'(s2_q[2*i]) + 38'(s2_q[2*i+1]);
      end
    end
    if (en[SO+2]) begin
      tot_q <= 39'(s4_q[0]) + 39'(s4_q[1]);
    end
    if (en[SO+3]) begin
      level_q   <= clip ? 8'hFF : scl[39:32];
      clipped_q <= clip;
    end
  end

  assign lvl_o.valid   = v_q[NS-1];
  assign lvl_o.level   = level_q;
  assign lvl_o.clipped = clipped_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> v_q[0])
    else $error("accepted pixel did not enter the pipeline");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !lvl_o.ready |=> v_q[NS-1])
    else $error("stalled result dropped");

  a_clip_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_o.valid && lvl_o.clipped |-> lvl_o.level == 8'hFF)
    else $error("clipped result not saturated");

endmodule
